// File: design/gradient_orientation_vote_quantizer_assert.svh
// Assertion macros shared by the orientation vote quantizer RTL.
// Needs nothing else; the checks compile away when SYNTHESIS is defined.
`ifndef GRADIENT_ORIENTATION_VOTE_QUANTIZER_ASSERT_SVH
`define GRADIENT_ORIENTATION_VOTE_QUANTIZER_ASSERT_SVH
`ifndef SYNTHESIS
// plain property, checked at every clock edge outside reset
`define GOVQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("govq assertion failed");
// same-cycle implication
`define GOVQ_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("govq implication failed");
`else
`define GOVQ_ASSERT(lbl, clk, rst, prop)
`define GOVQ_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/govq_pkg.sv
// Shared types and constants of the orientation vote quantizer.
// No dependencies; used by govq_vote and the top level.
`timescale 1ns / 1ps

package govq_pkg;

   // angle quantization: 32 buckets over 23040 steps is one bucket per 720
   localparam int ANGLE_STEP  = 720;
   localparam int ANGLE_HALF  = 360;
   // reciprocal of 720 scaled by 2^22, rounded down; estimate is low by at most one
   localparam int RECIP_MULT  = 5825;
   localparam int RECIP_SHIFT = 22;

   localparam int WEAK_LEVEL  = 16;   // 1.0 in 12.4 fixed point
   localparam int VOTE_MIN    = 3;

   localparam int WIN_DIM     = 3;
   localparam int WIN_TAPS    = WIN_DIM * WIN_DIM;
   localparam int WIN_CENTER  = WIN_TAPS / 2;

   localparam int NUM_BINS    = 16;   // width of the one-hot label
   localparam logic [3:0] MASK_EIGHT = 4'd7;

   localparam int OUT_DEPTH   = 8;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_BIN_MODE  = 2'd1,
      CSR_WIDTH     = 2'd2,
      CSR_HEIGHT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic       above_thr;
      logic       above_weak;
      logic [3:0] bin;
   } entry_type;

   typedef entry_type [WIN_TAPS-1:0] window_type;

   typedef struct packed {
      logic [15:0] out_row;
      logic [10:0] out_col;
      logic [15:0] label;
      logic        frame_end;
   } rsp_type;

endpackage

// File: design/govq_vote.sv
// 3x3 orientation vote: histogram, grouped arg-max, one-hot label.
// Uses govq_pkg; two register stages, label formed from the second.
`timescale 1ns / 1ps
`include "gradient_orientation_vote_quantizer_assert.svh"

module govq_vote (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  govq_pkg::window_type in_win,
   input  logic [3:0]           in_mask,
   input  govq_pkg::rsp_type    in_rsp,
   output logic                 out_vld,
   output govq_pkg::rsp_type    out_rsp
);

   localparam int GROUPS     = 4;
   localparam int GROUP_SIZE = govq_pkg::NUM_BINS / GROUPS;

   // stage A: histogram
   logic [3:0]        hist_in [govq_pkg::NUM_BINS];
   logic [3:0]        hist_ff [govq_pkg::NUM_BINS];
   logic              a_vld_ff;
   logic              a_ok_ff;
   govq_pkg::rsp_type a_rsp_ff;

   // stage B: per-group best
   logic [3:0]        grp_cnt_in [GROUPS];
   logic [1:0]        grp_idx_in [GROUPS];
   logic [3:0]        grp_cnt_ff [GROUPS];
   logic [1:0]        grp_idx_ff [GROUPS];
   logic              b_vld_ff;
   logic              b_ok_ff;
   govq_pkg::rsp_type b_rsp_ff;

   logic [3:0]        best;
   logic [3:0]        best_idx;

   always_comb begin
      for (int b = 0; b < govq_pkg::NUM_BINS; b++) begin
         hist_in[b] = '0;
         for (int t = 0; t < govq_pkg::WIN_TAPS; t++) begin
            if ((t == govq_pkg::WIN_CENTER || in_win[t].above_weak) &&
                ((in_win[t].bin & in_mask) == 4'(b)) && (4'(b) <= in_mask)) begin
               hist_in[b] = hist_in[b] + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
      end
      hist_ff  <= hist_in;
      a_ok_ff  <= in_win[govq_pkg::WIN_CENTER].above_thr;
      a_rsp_ff <= in_rsp;
      grp_cnt_ff <= grp_cnt_in;
      grp_idx_ff <= grp_idx_in;
      b_ok_ff    <= a_ok_ff;
      b_rsp_ff   <= a_rsp_ff;
   end

   // strict compare keeps the lowest index on ties
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_cnt_in[g] = hist_ff[g*GROUP_SIZE];
         grp_idx_in[g] = 2'd0;
         for (int k = 1; k < GROUP_SIZE; k++) begin
            if (hist_ff[g*GROUP_SIZE+k] > grp_cnt_in[g]) begin
               grp_cnt_in[g] = hist_ff[g*GROUP_SIZE+k];
               grp_idx_in[g] = 2'(k);
            end
         end
      end
   end

   always_comb begin
      best     = grp_cnt_ff[0];
      best_idx = {2'd0, grp_idx_ff[0]};
      for (int g = 1; g < GROUPS; g++) begin
         if (grp_cnt_ff[g] > best) begin
            best     = grp_cnt_ff[g];
            best_idx = {2'(g), grp_idx_ff[g]};
         end
      end
      out_rsp       = b_rsp_ff;
      out_rsp.label = (b_ok_ff && best >= 4'(govq_pkg::VOTE_MIN)) ?
                      (16'd1 << best_idx) : 16'd0;
   end

   assign out_vld = b_vld_ff;

   `GOVQ_IMPLY(a_label_onehot, clock, reset, out_vld, $onehot0(out_rsp.label))
   `GOVQ_IMPLY(a_weak_no_label, clock, reset, out_vld && !b_ok_ff, out_rsp.label == 16'd0)
   `GOVQ_IMPLY(a_stage_follow, clock, reset, out_vld, $past(a_vld_ff))

endmodule

// File: design/gradient_orientation_vote_quantizer.sv
// Top level of the gradient orientation vote quantizer.
// Uses govq_pkg and govq_vote; line buffers and output queue live here.
`timescale 1ns / 1ps
`include "gradient_orientation_vote_quantizer_assert.svh"

// Usage
//   req_*  : one gradient pixel per item, raster order (magnitude 12.4, angle 1/64 deg).
//   rsp_*  : one item per interior pixel (row, col, one-hot label, frame_end);
//            border pixels produce nothing. The result for pixel (r-1, c-1)
//            comes out once pixel (r, c) has been taken.
//   csr_*  : register writes (threshold, bin mode, width, height), always ready;
//            write only while no item is in flight.
// Timing
//   One item per clock while req_ready is high. A result is presented once the item
//   that completes its window is accepted and has passed quantize and line read,
//   window shift and line write-back, histogram, arg-max and the output queue.
//   The line buffer is one synchronous memory (upper/middle pair per column),
//   read at accept and written back the next cycle; a width of at least 3
//   keeps any column's next read behind its write-back.
// Stalls
//   Results wait in an 8-entry queue. req_ready drops only when 8 results are
//   owed to the receiver, so a stalled receiver holds back input only then.
// Reset
//   Clears counters, window, queue and registers to their defaults. Line
//   memory is not cleared; every entry is written before a result uses it.
module gradient_orientation_vote_quantizer #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_BINS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_magnitude,
   input  logic [14:0] req_angle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_out_row,
   output logic [10:0] rsp_out_col,
   output logic [15:0] rsp_label,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CW      = $clog2(MAX_WIDTH);       // column counter / memory index
   localparam int WW      = $clog2(MAX_WIDTH + 1);   // effective width
   localparam int RECIP_W = $clog2(govq_pkg::RECIP_MULT + 1);
   localparam int PROD_W  = 15 + RECIP_W;
   localparam logic [3:0] MODE1_MASK = 4'(MAX_BINS - 1);

   typedef struct packed {
      govq_pkg::entry_type upper;
      govq_pkg::entry_type middle;
   } line_pair_type;

   // registers
   logic [11:0] csr_thr_ff;
   logic        csr_mode_ff;
   logic [11:0] csr_width_ff;
   logic [15:0] csr_height_ff;

   logic [CW-1:0] col_ff;
   logic [15:0]   row_ff;

   // accept stage
   logic          req_fire;
   logic          rsp_fire;
   logic [WW-1:0] width_last;
   logic [15:0]   height_last;
   logic          emit;
   logic          col_wrap;
   logic          row_wrap;
   logic [CW-1:0] col_m1;
   logic [PROD_W-1:0] prod;
   logic [3:0]    bin_mask;
   govq_pkg::rsp_type s1_rsp_in;

   // stage 1: finish quantization, write back line pair, shift window
   logic              s1_vld_ff;
   logic              s1_emit_ff;
   govq_pkg::rsp_type s1_rsp_ff;
   logic [CW-1:0]     s1_col_ff;
   logic [14:0]       s1_angle_ff;
   logic [PROD_W-govq_pkg::RECIP_SHIFT-1:0] s1_quo_ff;
   logic              s1_weak_ff;
   logic              s1_thr_ff;
   line_pair_type     line_rd_ff;
   line_pair_type     line_mem [MAX_WIDTH];

   logic [15:0] rem_raw;
   logic [10:0] rem;
   logic [5:0]  quo;
   logic [4:0]  half_quo;
   logic [10:0] half_rem;
   logic        round_up;
   logic [5:0]  bucket;
   govq_pkg::entry_type s1_entry;

   govq_pkg::window_type window_ff;

   // stage 2: vote input
   logic              s2_vld_ff;
   govq_pkg::rsp_type s2_rsp_ff;

   logic              vote_vld;
   govq_pkg::rsp_type vote_rsp;

   // output queue
   govq_pkg::rsp_type fifo_mem [govq_pkg::OUT_DEPTH];
   logic [govq_pkg::OUT_PTR_W-1:0] wr_ptr_ff;
   logic [govq_pkg::OUT_PTR_W-1:0] rd_ptr_ff;
   logic [govq_pkg::OUT_CNT_W-1:0] fifo_cnt_ff;
   logic [govq_pkg::OUT_CNT_W-1:0] occ_ff;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_thr_ff    <= 12'd20;
         csr_mode_ff   <= 1'b0;
         csr_width_ff  <= 12'd640;
         csr_height_ff <= 16'd480;
      end else if (csr_valid && csr_ready) begin
         unique case (govq_pkg::csr_index_type'(csr_index))
            govq_pkg::CSR_THRESHOLD: csr_thr_ff    <= csr_wdata[11:0];
            govq_pkg::CSR_BIN_MODE:  csr_mode_ff   <= csr_wdata[0];
            govq_pkg::CSR_WIDTH:     csr_width_ff  <= csr_wdata[11:0];
            govq_pkg::CSR_HEIGHT:    csr_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign bin_mask = csr_mode_ff ? MODE1_MASK : govq_pkg::MASK_EIGHT;

   // ---------------- geometry and counters ----------------
   always_comb begin
      if (csr_width_ff < 12'd3) begin
         width_last = WW'(2);
      end else if (32'(csr_width_ff) > 32'(MAX_WIDTH)) begin
         width_last = WW'(MAX_WIDTH - 1);
      end else begin
         width_last = WW'(csr_width_ff - 12'd1);
      end
      height_last = (csr_height_ff < 16'd3) ? 16'd2 : (csr_height_ff - 16'd1);
   end

   assign req_ready = occ_ff < govq_pkg::OUT_CNT_W'(govq_pkg::OUT_DEPTH);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // counters past the limit after a geometry change wrap without output
   assign col_wrap = WW'(col_ff) >= width_last;
   assign row_wrap = row_ff >= height_last;
   assign emit     = (row_ff >= 16'd2) && (col_ff >= CW'(2)) &&
                     (row_ff <= height_last) && (WW'(col_ff) <= width_last);
   assign col_m1   = col_ff - CW'(1);

   always_comb begin
      s1_rsp_in           = '0;
      s1_rsp_in.out_row   = row_ff - 16'd1;
      s1_rsp_in.out_col   = 11'(col_m1);
      s1_rsp_in.frame_end = (row_ff == height_last) && (WW'(col_ff) == width_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_wrap ? 16'd0 : (row_ff + 16'd1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // coarse quotient angle / 720, low by at most one
   assign prod = PROD_W'(req_angle) * PROD_W'(govq_pkg::RECIP_MULT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_fire;
      end
      if (req_fire) begin
         s1_emit_ff  <= emit;
         s1_rsp_ff   <= s1_rsp_in;
         s1_col_ff   <= col_ff;
         s1_angle_ff <= req_angle;
         s1_quo_ff   <= prod[PROD_W-1:govq_pkg::RECIP_SHIFT];
         s1_weak_ff  <= req_magnitude > 16'(govq_pkg::WEAK_LEVEL);
         s1_thr_ff   <= req_magnitude > {csr_thr_ff, 4'd0};
      end
   end

   // ---------------- stage 1: rounding ----------------
   assign rem_raw = {1'b0, s1_angle_ff} -
                    (16'(s1_quo_ff) * 16'(govq_pkg::ANGLE_STEP));

   always_comb begin
      rem = rem_raw[10:0];
      quo = 6'(s1_quo_ff);
      if (rem >= 11'(govq_pkg::ANGLE_STEP)) begin
         rem = rem - 11'(govq_pkg::ANGLE_STEP);
         quo = quo + 6'd1;
      end
      half_quo = quo[5:1];
      half_rem = quo[0] ? (rem + 11'(govq_pkg::ANGLE_STEP)) : rem;
      // round half to even
      if (csr_mode_ff) begin
         round_up = (rem > 11'(govq_pkg::ANGLE_HALF)) ||
                    ((rem == 11'(govq_pkg::ANGLE_HALF)) && quo[0]);
         bucket   = quo + 6'(round_up);
      end else begin
         round_up = (half_rem > 11'(govq_pkg::ANGLE_STEP)) ||
                    ((half_rem == 11'(govq_pkg::ANGLE_STEP)) && half_quo[0]);
         bucket   = {1'b0, half_quo} + 6'(round_up);
      end
      s1_entry.above_thr  = s1_thr_ff;
      s1_entry.above_weak = s1_weak_ff;
      s1_entry.bin        = bucket[3:0] & bin_mask;
   end

   // ---------------- line memory ----------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_rd_ff <= line_mem[col_ff];
      end
      if (s1_vld_ff) begin
         line_mem[s1_col_ff] <= {line_rd_ff.middle, s1_entry};
      end
   end

   // window taps are row*3+col, newest column on the right
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_vld_ff) begin
         for (int i = 0; i < govq_pkg::WIN_DIM; i++) begin
            window_ff[i*govq_pkg::WIN_DIM]     <= window_ff[i*govq_pkg::WIN_DIM + 1];
            window_ff[i*govq_pkg::WIN_DIM + 1] <= window_ff[i*govq_pkg::WIN_DIM + 2];
         end
         window_ff[2] <= line_rd_ff.upper;
         window_ff[5] <= line_rd_ff.middle;
         window_ff[8] <= s1_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff && s1_emit_ff;
      end
      s2_rsp_ff <= s1_rsp_ff;
   end

   govq_vote u_vote (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (s2_vld_ff),
      .in_win  (window_ff),
      .in_mask (bin_mask),
      .in_rsp  (s2_rsp_ff),
      .out_vld (vote_vld),
      .out_rsp (vote_rsp)
   );

   // ---------------- output queue ----------------
   // occ_ff counts results owed: accepted with output, not yet taken
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         occ_ff      <= '0;
      end else begin
         if (vote_vld) begin
            wr_ptr_ff <= wr_ptr_ff + govq_pkg::OUT_PTR_W'(1);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + govq_pkg::OUT_PTR_W'(1);
         end
         priority if (vote_vld && !rsp_fire) begin
            fifo_cnt_ff <= fifo_cnt_ff + govq_pkg::OUT_CNT_W'(1);
         end else if (!vote_vld && rsp_fire) begin
            fifo_cnt_ff <= fifo_cnt_ff - govq_pkg::OUT_CNT_W'(1);
         end else begin
            fifo_cnt_ff <= fifo_cnt_ff;
         end
         priority if (req_fire && emit && !rsp_fire) begin
            occ_ff <= occ_ff + govq_pkg::OUT_CNT_W'(1);
         end else if (!(req_fire && emit) && rsp_fire) begin
            occ_ff <= occ_ff - govq_pkg::OUT_CNT_W'(1);
         end else begin
            occ_ff <= occ_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (vote_vld) begin
         fifo_mem[wr_ptr_ff] <= vote_rsp;
      end
   end

   assign rsp_valid     = fifo_cnt_ff != '0;
   assign rsp_out_row   = fifo_mem[rd_ptr_ff].out_row;
   assign rsp_out_col   = fifo_mem[rd_ptr_ff].out_col;
   assign rsp_label     = fifo_mem[rd_ptr_ff].label;
   assign rsp_frame_end = fifo_mem[rd_ptr_ff].frame_end;

   `GOVQ_ASSERT(a_occ_bound, clock, reset,
      occ_ff <= govq_pkg::OUT_CNT_W'(govq_pkg::OUT_DEPTH))
   `GOVQ_ASSERT(a_fifo_within_owed, clock, reset, fifo_cnt_ff <= occ_ff)
   `GOVQ_IMPLY(a_push_has_room, clock, reset, vote_vld,
      fifo_cnt_ff < govq_pkg::OUT_CNT_W'(govq_pkg::OUT_DEPTH))
   `GOVQ_IMPLY(a_rsp_onehot, clock, reset, rsp_valid, $onehot0(rsp_label))

endmodule
